### src/merge_sorter_core_assert.svh
// assertion macros shared by ms_datapath and ms_ctrl
// every module using them names its clock "clock" and its reset "reset"
`ifndef MERGE_SORTER_CORE_ASSERT_SVH
`define MERGE_SORTER_CORE_ASSERT_SVH

`define MS_ASSERT_IMPLIES(lbl, cond, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("merge sorter check failed");

`define MS_ASSERT_NEXT(lbl, cond, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("merge sorter check failed");

`endif

### src/ms_pkg.sv
package ms_pkg;

   localparam int DEPTH     = 64;
   localparam int KEY_WIDTH = 32;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int SUM_W     = CNT_W + 1;

   typedef logic signed [KEY_WIDTH-1:0] key_type;
   typedef logic [ADDR_W-1:0]           addr_type;
   typedef logic [CNT_W-1:0]            cnt_type;
   typedef logic [SUM_W-1:0]            sum_type;

   typedef struct packed {
      key_type key_in;
      logic    last_in;
   } req_type;

   typedef struct packed {
      key_type key_out;
      logic    last_out;
      logic    overflow;
   } rsp_type;

   typedef struct packed {
      logic    load;
      logic    run_init;
      logic    step;
      logic    swap;
      logic    out_init;
      logic    emit;
      logic    clear;
      cnt_type lo;
      cnt_type mid;
      cnt_type hi;
   } cmd_type;

   typedef struct packed {
      cnt_type count;
      logic    run_last;
      logic    out_last;
   } status_type;

endpackage

### src/ms_datapath.sv
`include "merge_sorter_core_assert.svh"

module ms_datapath import ms_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_valid,
   output rsp_type    rsp
);

   key_type bank0_mem [DEPTH];
   key_type bank1_mem [DEPTH];
   key_type rd0_a_ff, rd0_b_ff, rd1_a_ff, rd1_b_ff;

   cnt_type count_ff, count_in;
   logic    dropped_ff, dropped_in;
   logic    src_sel_ff, src_sel_in;
   cnt_type i_ff, i_in, j_ff, j_in, k_ff, k_in, mid_ff, mid_in, hi_ff, hi_in;
   cnt_type k_plus;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   key_type  left_key, right_key, wdata;
   logic     take_left, full, we0, we1;
   addr_type addr_a, addr_b, waddr;

   always_comb begin
      left_key  = src_sel_ff ? rd1_a_ff : rd0_a_ff;
      right_key = src_sel_ff ? rd1_b_ff : rd0_b_ff;
      // right run wins ties, and an exhausted run is never taken
      take_left = (i_ff < mid_ff) && ((j_ff >= hi_ff) || (left_key < right_key));
      full      = (count_ff >= CNT_W'(DEPTH));
      k_plus    = k_ff + 1'b1;

      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      mid_in     = mid_ff;
      hi_in      = hi_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      src_sel_in = src_sel_ff;
      we0        = 1'b0;
      we1        = 1'b0;
      waddr      = k_ff[ADDR_W-1:0];
      wdata      = take_left ? left_key : right_key;

      if (cmd.load) begin
         waddr = count_ff[ADDR_W-1:0];
         wdata = req.key_in;
         if (full) begin
            dropped_in = 1'b1;
         end else begin
            we0      = 1'b1;
            count_in = count_ff + 1'b1;
         end
      end
      if (cmd.run_init) begin
         i_in   = cmd.lo;
         j_in   = cmd.mid;
         k_in   = cmd.lo;
         mid_in = cmd.mid;
         hi_in  = cmd.hi;
      end
      if (cmd.step) begin
         k_in = k_plus;
         we0  = src_sel_ff;
         we1  = ~src_sel_ff;
         if (take_left) begin
            i_in = i_ff + 1'b1;
         end else begin
            j_in = j_ff + 1'b1;
         end
      end
      if (cmd.swap) begin
         src_sel_in = ~src_sel_ff;
      end
      if (cmd.out_init) begin
         k_in = '0;
      end
      if (cmd.emit) begin
         k_in = k_plus;
      end
      if (cmd.clear) begin
         count_in   = '0;
         dropped_in = 1'b0;
         src_sel_in = 1'b0;
      end

      // read addresses follow the next pointers so the registered read data is ready in the next cycle
      addr_a = (cmd.out_init || cmd.emit) ? k_in[ADDR_W-1:0] : i_in[ADDR_W-1:0];
      addr_b = j_in[ADDR_W-1:0];

      status.count    = count_ff;
      status.run_last = (k_plus == hi_ff);
      status.out_last = (k_plus == count_ff);

      rsp_valid_in     = cmd.emit;
      rsp_in.key_out   = left_key;
      rsp_in.last_out  = status.out_last;
      rsp_in.overflow  = dropped_ff;
   end

   always_ff @(posedge clock) begin
      if (we0) begin
         bank0_mem[waddr] <= wdata;
      end
      rd0_a_ff <= bank0_mem[addr_a];
      rd0_b_ff <= bank0_mem[addr_b];
   end

   always_ff @(posedge clock) begin
      if (we1) begin
         bank1_mem[waddr] <= wdata;
      end
      rd1_a_ff <= bank1_mem[addr_a];
      rd1_b_ff <= bank1_mem[addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         src_sel_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         src_sel_ff   <= src_sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff   <= i_in;
      j_ff   <= j_in;
      k_ff   <= k_in;
      mid_ff <= mid_in;
      hi_ff  <= hi_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `MS_ASSERT_NEXT(a_burst_ends_after_last, rsp_valid_ff && rsp_ff.last_out, !rsp_valid_ff)
   `MS_ASSERT_IMPLIES(a_step_inside_run, cmd.step, (k_ff < hi_ff) && (i_ff <= mid_ff))

endmodule

### src/ms_ctrl.sv
`include "merge_sorter_core_assert.svh"

module ms_ctrl import ms_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       last_in,
   input  status_type status,
   output logic       busy,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_PASS = 4'b0010,
      S_RUN  = 4'b0100,
      S_OUT  = 4'b1000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   sum_type        width_ff, width_in, lo_ff, lo_in;
   sum_type        n_sum, lo_w, lo_2w;
   logic           accept;

   always_comb begin
      n_sum  = SUM_W'(status.count);
      lo_w   = lo_ff + width_ff;
      lo_2w  = lo_ff + (width_ff << 1);
      accept = start && (state_ff == S_IDLE);

      state_in = state_ff;
      width_in = width_ff;
      lo_in    = lo_ff;
      cmd      = '0;
      cmd.lo   = lo_ff[CNT_W-1:0];
      cmd.mid  = (lo_w > n_sum) ? status.count : lo_w[CNT_W-1:0];
      cmd.hi   = (lo_2w > n_sum) ? status.count : lo_2w[CNT_W-1:0];

      case (state_ff)
         S_IDLE: begin
            cmd.load = accept;
            if (accept && last_in) begin
               width_in = SUM_W'(1);
               lo_in    = '0;
               state_in = S_PASS;
            end
         end
         S_PASS: begin
            if (width_ff >= n_sum) begin
               cmd.out_init = 1'b1;
               state_in     = S_OUT;
            end else if (lo_ff >= n_sum) begin
               // pass finished, runs double and the banks trade roles
               cmd.swap = 1'b1;
               width_in = width_ff << 1;
               lo_in    = '0;
            end else begin
               cmd.run_init = 1'b1;
               state_in     = S_RUN;
            end
         end
         S_RUN: begin
            cmd.step = 1'b1;
            if (status.run_last) begin
               lo_in    = lo_2w;
               state_in = S_PASS;
            end
         end
         S_OUT: begin
            cmd.emit = 1'b1;
            if (status.out_last) begin
               cmd.clear = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      busy = (state_ff != S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      width_ff <= width_in;
      lo_ff    <= lo_in;
   end

   `MS_ASSERT_IMPLIES(a_idle_only_after_last, !$past(reset) && $fell(busy), $past(status.out_last))
   `MS_ASSERT_IMPLIES(a_run_inside_block, state_ff == S_RUN, lo_ff < n_sum)

endmodule

### src/merge_sorter_core.sv
// Block merge sorter for signed keys. Keys are loaded one per cycle while busy
// is low; the request with last_in set closes the block (up to DEPTH keys are
// kept, further keys are dropped and flag overflow on every result of that
// block). The block then sorts bottom-up with two ping-pong key banks and a
// single compare unit that moves one key per cycle while merging a run: there
// are ceil(log2 n) passes over the n keys, each merging pairs of runs, followed
// by the n results. Results appear on rsp one per cycle with rsp_valid high for
// exactly that cycle, in ascending order, last_out marking the final key; the
// receiver cannot stall them and must take every one. busy rises after the
// closing request and falls in the cycle in which the final result appears on
// rsp.
module merge_sorter_core import ms_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req,
   output logic    busy,
   output logic    rsp_valid,
   output rsp_type rsp
);

   cmd_type    cmd;
   status_type status;

   ms_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .last_in (req.last_in),
      .status  (status),
      .busy    (busy),
      .cmd     (cmd)
   );

   ms_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

endmodule

### sim/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ms_pkg::*;

   localparam key_type KEY_MAX = {1'b0, {(KEY_WIDTH-1){1'b1}}};
   localparam key_type KEY_MIN = {1'b1, {(KEY_WIDTH-1){1'b0}}};

   logic    clock;
   logic    reset;
   logic    start;
   req_type req;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp;

   // keys of the block being loaded, and the sorted results still to come
   key_type block_keys[$];
   bit      block_dropped;
   rsp_type pending_sorted[$];
   int      err_count;
   int      idle_pct;

   merge_sorter_core uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // store the key while the block has room, and on the closing request sort the block into expected results
   function automatic void absorb_key(req_type r);
      key_type k;
      rsp_type e;
      int      n;
      int      j;
      if (block_keys.size() < DEPTH) begin
         block_keys.push_back(r.key_in);
      end else begin
         block_dropped = 1'b1;
      end
      if (r.last_in) begin
         n = block_keys.size();
         for (int i = 1; i < n; i++) begin
            k = block_keys[i];
            j = i;
            while (j > 0 && block_keys[j-1] > k) begin
               block_keys[j] = block_keys[j-1];
               j--;
            end
            block_keys[j] = k;
         end
         for (int i = 0; i < n; i++) begin
            e.key_out  = block_keys[i];
            e.last_out = (i == n - 1);
            e.overflow = block_dropped;
            pending_sorted.push_back(e);
         end
         block_keys.delete();
         block_dropped = 1'b0;
      end
   endfunction

   task automatic send_key(input key_type key, input logic last);
      req_type r;
      r.key_in  = key;
      r.last_in = last;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req   <= r;
      do @(posedge clock); while (busy);
      absorb_key(r);
   endtask

   // hold off the sender until every sorted key has come back
   task automatic settle();
      start <= 1'b0;
      while (pending_sorted.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid) begin
         if (pending_sorted.size() == 0) begin
            $error("unexpected result: key_out %0d", rsp.key_out);
            err_count++;
         end else begin
            e = pending_sorted.pop_front();
            if (rsp.key_out !== e.key_out) begin
               $error("key_out mismatch: expected %0d, got %0d", e.key_out, rsp.key_out);
               err_count++;
            end
            if (rsp.last_out !== e.last_out) begin
               $error("last_out mismatch: expected %0b, got %0b", e.last_out, rsp.last_out);
               err_count++;
            end
            if (rsp.overflow !== e.overflow) begin
               $error("overflow mismatch: expected %0b, got %0b", e.overflow, rsp.overflow);
               err_count++;
            end
         end
      end
   end

   task automatic test_single_keys();
      send_key(KEY_MIN, 1'b1);
      send_key(KEY_MAX, 1'b1);
      settle();
   endtask

   task automatic test_extremes();
      send_key(KEY_MAX, 1'b0);
      send_key(KEY_MIN, 1'b0);
      send_key('0, 1'b0);
      send_key(-1, 1'b0);
      send_key(1, 1'b0);
      send_key(KEY_MIN, 1'b0);
      send_key(KEY_MAX, 1'b1);
      settle();
   endtask

   task automatic test_reverse_and_equal();
      for (int i = 0; i < 8; i++) send_key(key_type'(100 - 30 * i), i == 7);
      for (int i = 0; i < 4; i++) send_key(-7, i == 3);
      settle();
   endtask

   // 66 keys: the 65th is dropped and so is the closing one
   task automatic test_overflow();
      for (int i = 0; i < DEPTH + 2; i++) send_key(key_type'($urandom), i == DEPTH + 1);
      settle();
   endtask

   task automatic test_random(input int pct, input int n_items);
      int      sent;
      int      blk_len;
      key_type k;
      idle_pct = pct;
      sent     = 0;
      while (sent < n_items) begin
         blk_len = $urandom_range(1, 9);
         for (int i = 0; i < blk_len; i++) begin
            case ($urandom_range(3))
               0, 1: k = key_type'($urandom);
               2: k = key_type'($urandom_range(8)) - 4;
               default: k = $urandom_range(1) ? KEY_MAX : KEY_MIN;
            endcase
            send_key(k, i == blk_len - 1);
         end
         sent += blk_len;
      end
      settle();
   endtask

   initial begin
      err_count     = 0;
      idle_pct      = 0;
      block_dropped = 1'b0;
      reset <= 1'b1;
      start <= 1'b0;
      req   <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_single_keys();
      test_extremes();
      test_reverse_and_equal();
      test_overflow();
      test_random(0, 3);
      test_random(62, 3);
      test_random(0, 3);
      test_random(12, 3);

      if (err_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
